[rtl/core/ssvc_pkg.sv]
`default_nettype none
package ssvc_pkg;

	localparam int W16       = 16;
	localparam int CFG_IDX_W = 3;
	localparam int LIM_W     = 15;
	localparam int MUL_A_W   = 46;
	localparam int MUL_B_W   = 16;
	localparam int PROD_W    = MUL_A_W + MUL_B_W + 1;
	localparam int DIV_N_W   = 32;
	localparam int DIV_D_W   = 16;

	localparam logic [W16-1:0]   RST_WHEEL_RADIUS = 16'd2048;
	localparam logic [W16-1:0]   RST_TRACK_WIDTH  = 16'd8192;
	localparam logic [W16-1:0]   RST_KP_LINEAR    = 16'd2560;
	localparam logic [W16-1:0]   RST_KD_LINEAR    = 16'd0;
	localparam logic [W16-1:0]   RST_KP_ANGULAR   = 16'd5120;
	localparam logic [W16-1:0]   RST_KD_ANGULAR   = 16'd0;
	localparam logic [W16-1:0]   RST_WHEEL_GAIN   = 16'd2560;
	localparam logic [LIM_W-1:0] RST_EFFORT_LIMIT = 15'd10240;

	// reference clamps, Q7.8
	localparam logic signed [W16-1:0] VREF_MAX = 16'sd2560;
	localparam logic signed [W16-1:0] VREF_MIN = -16'sd2560;
	localparam logic signed [W16-1:0] WREF_MAX = 16'sd256;
	localparam logic signed [W16-1:0] WREF_MIN = -16'sd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEEL_RADIUS,
		REG_TRACK_WIDTH,
		REG_KP_LINEAR,
		REG_KD_LINEAR,
		REG_KP_ANGULAR,
		REG_KD_ANGULAR,
		REG_WHEEL_GAIN,
		REG_EFFORT_LIMIT
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_VL,
		S_VR,
		S_LIN,
		S_DIV,
		S_DIVW,
		S_ERR,
		S_KDV,
		S_KPW,
		S_KDW,
		S_UW,
		S_H,
		S_D,
		S_E0,
		S_E1,
		S_E2,
		S_E3,
		S_E4,
		S_OUT
	} ssvc_state_t;

	typedef struct packed {
		logic signed [W16-1:0] speed_back_left;
		logic signed [W16-1:0] speed_front_left;
		logic signed [W16-1:0] speed_back_right;
		logic signed [W16-1:0] speed_front_right;
		logic signed [W16-1:0] linear_target;
		logic signed [W16-1:0] angular_target;
	} ssvc_in_t;

	typedef struct packed {
		logic signed [W16-1:0] effort_back_left;
		logic signed [W16-1:0] effort_front_left;
		logic signed [W16-1:0] effort_back_right;
		logic signed [W16-1:0] effort_front_right;
		logic signed [W16-1:0] body_linear_speed;
		logic signed [W16-1:0] body_angular_speed;
	} ssvc_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

[rtl/core/ssvc_stream_if.sv]
`default_nettype none
interface ssvc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/ssvc_div.sv]
`default_nettype none
module ssvc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ssvc_pkg::DIV_N_W-1:0]  dividend,
	input  logic [ssvc_pkg::DIV_D_W-1:0]  divisor,
	output logic [ssvc_pkg::DIV_N_W-1:0]  quotient,
	output ssvc_pkg::div_stat_t           stat
);
	import ssvc_pkg::*;

	localparam int CNT_W = $clog2(DIV_N_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N_W - 1);

	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] den_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [DIV_D_W:0]   shifted;
	logic [DIV_D_W+1:0] trial;

	assign shifted = {rem_q, quo_q[DIV_N_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_D_W+1]) begin
				rem_q <= trial[DIV_D_W-1:0];
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_D_W-1:0];
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

[rtl/core/skid_steer_velocity_controller.sv]
`default_nettype none
// Channel   Dir  Payload                  Flow control
// request   in   ssvc_in_t, 6 x 16 bit    valid / ready
// result    out  ssvc_out_t, 6 x 16 bit   valid / ready
// cfg       in   3 bit index, 16 bit data cfg_we, always taken
//
// Each beat runs through single steps of the shared 46x17 multiplier around
// the bit-serial divider for the turn rate; a new beat is taken only in idle,
// once the previous result has been loaded into the result register.
// The result register holds a beat until taken; a new result waits in the
// last step while the previous beat is still pending.
// Reset loads the register defaults and clears the PD error history.
module skid_steer_velocity_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ssvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssvc_pkg::W16-1:0]        cfg_wdata,
	ssvc_stream_if.sink                     request,
	ssvc_stream_if.source                   result
);
	import ssvc_pkg::*;

	localparam int AW = MUL_A_W;

	localparam logic signed [34:0] EW_MAX  = 35'sh0_7FFF_FFFF;
	localparam logic signed [34:0] EW_MIN  = -35'sh0_8000_0000;
	localparam logic signed [18:0] LIN_MAX = 19'sd32767;
	localparam logic signed [18:0] LIN_MIN = -19'sd32768;
	localparam logic signed [33:0] ANG_MAX = 34'sd32767;
	localparam logic signed [33:0] ANG_MIN = -34'sd32768;

	// configuration
	logic [W16-1:0]   wheel_radius_q, track_width_q, kp_linear_q, kd_linear_q;
	logic [W16-1:0]   kp_angular_q, kd_angular_q, wheel_gain_q;
	logic [LIM_W-1:0] effort_limit_q;

	// sequencer and datapath
	ssvc_state_t state_q, state_d;

	logic [W16-1:0]    wbl_q, wfl_q, wbr_q, wfr_q, vref_q, wref_q;
	logic [18:0]       vl_q, vr_q, lin_q;
	logic              diff_neg_q;
	logic [19:0]       ev_q;
	logic [33:0]       ang_q;
	logic [31:0]       ew_q;
	logic [31:0]       last_lin_q, last_ang_q;
	logic [PROD_W-1:0] prod_q, acc_q;
	logic [41:0]       uv_q, uw_q;
	logic [43:0]       dl_q, dr_q;
	logic [W16-1:0]    eff_bl_q, eff_fl_q, eff_br_q, eff_fr_q;

	ssvc_out_t rsp_q;
	logic      rsp_valid_q;

	// shared multiplier
	logic signed [AW-1:0]   mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [PROD_W-1:0]      product;

	logic                   div_start;
	logic [DIV_N_W-1:0]     div_quo;
	div_stat_t              div_stat;

	logic [W16-1:0]    track_eff;
	logic [16:0]       sum_left, sum_right;
	logic [17:0]       neg_right;
	logic [19:0]       lin_sum, diff, abs_diff, ev;
	logic [32:0]       ev_d, ew_d;
	logic [34:0]       ew_full;
	logic [31:0]       ew_sat;
	logic [PROD_W-1:0] pd_sum;
	logic [42:0]       h;
	logic [43:0]       uv_x, h_x, d_sel;
	logic [W16-1:0]    w_sel;
	logic [44:0]       dw;
	logic              rsp_free;
	logic [W16-1:0]    vref_in, wref_in;
	logic signed [W16-1:0] eff_cur;

	function automatic logic [W16-1:0] sat_lim(input logic [PROD_W-1:0] p,
		input logic [LIM_W-1:0] lim);
		logic signed [PROD_W-9:0] e;
		logic signed [PROD_W-9:0] l;
		e = $signed(p[PROD_W-1:8]);
		l = $signed({{(PROD_W-8-LIM_W){1'b0}}, lim});
		if (e > l)
			return {1'b0, lim};
		else if (e < -l)
			return W16'(-l);
		else
			return e[W16-1:0];
	endfunction

	assign track_eff = (track_width_q == '0) ? 16'd1 : track_width_q;
	assign sum_left  = {wbl_q[15], wbl_q} + {wfl_q[15], wfl_q};
	assign sum_right = {wbr_q[15], wbr_q} + {wfr_q[15], wfr_q};
	assign neg_right = 18'd0 - {sum_right[16], sum_right};
	assign lin_sum   = {vl_q[18], vl_q} + {vr_q[18], vr_q};
	assign diff      = {vr_q[18], vr_q} - {vl_q[18], vl_q};
	assign abs_diff  = diff[19] ? (20'd0 - diff) : diff;
	assign ev        = {{4{vref_q[15]}}, vref_q} - {lin_sum[19], lin_sum[19:1]};
	assign ev_d      = {{13{ev_q[19]}}, ev_q} - {last_lin_q[31], last_lin_q};
	assign ew_d      = {ew_q[31], ew_q} - {last_ang_q[31], last_ang_q};
	assign ew_full   = {{19{wref_q[15]}}, wref_q} - {ang_q[33], ang_q};
	assign ew_sat    = ($signed(ew_full) > EW_MAX) ? 32'h7FFF_FFFF :
	                   ($signed(ew_full) < EW_MIN) ? 32'h8000_0000 : ew_full[31:0];
	assign pd_sum    = acc_q + prod_q;
	assign h         = prod_q[57:15];
	assign uv_x      = {{2{uv_q[41]}}, uv_q};
	assign h_x       = {h[42], h};
	assign dw        = {d_sel[43], d_sel} - {{29{w_sel[15]}}, w_sel};
	assign rsp_free  = !rsp_valid_q || result.ready;
	assign eff_cur   = $signed(sat_lim(prod_q, effort_limit_q));

	assign vref_in = ($signed(request.data.linear_target) > VREF_MAX) ? VREF_MAX :
	                 ($signed(request.data.linear_target) < VREF_MIN) ? VREF_MIN :
	                 request.data.linear_target;
	assign wref_in = ($signed(request.data.angular_target) > WREF_MAX) ? WREF_MAX :
	                 ($signed(request.data.angular_target) < WREF_MIN) ? WREF_MIN :
	                 request.data.angular_target;

	assign product = mul_a * $signed({1'b0, mul_b});

	ssvc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({abs_diff[17:0], 14'd0}),
		.divisor  (track_eff),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_radius_q <= RST_WHEEL_RADIUS;
			track_width_q  <= RST_TRACK_WIDTH;
			kp_linear_q    <= RST_KP_LINEAR;
			kd_linear_q    <= RST_KD_LINEAR;
			kp_angular_q   <= RST_KP_ANGULAR;
			kd_angular_q   <= RST_KD_ANGULAR;
			wheel_gain_q   <= RST_WHEEL_GAIN;
			effort_limit_q <= RST_EFFORT_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WHEEL_RADIUS: wheel_radius_q <= cfg_wdata;
				REG_TRACK_WIDTH:  track_width_q  <= cfg_wdata;
				REG_KP_LINEAR:    kp_linear_q    <= cfg_wdata;
				REG_KD_LINEAR:    kd_linear_q    <= cfg_wdata;
				REG_KP_ANGULAR:   kp_angular_q   <= cfg_wdata;
				REG_KD_ANGULAR:   kd_angular_q   <= cfg_wdata;
				REG_WHEEL_GAIN:   wheel_gain_q   <= cfg_wdata;
				REG_EFFORT_LIMIT: effort_limit_q <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (request.valid) state_d = S_VL;
			S_VL:    state_d = S_VR;
			S_VR:    state_d = S_LIN;
			S_LIN:   state_d = S_DIV;
			S_DIV:   state_d = S_DIVW;
			S_DIVW:  if (div_stat.done) state_d = S_ERR;
			S_ERR:   state_d = S_KDV;
			S_KDV:   state_d = S_KPW;
			S_KPW:   state_d = S_KDW;
			S_KDW:   state_d = S_UW;
			S_UW:    state_d = S_H;
			S_H:     state_d = S_D;
			S_D:     state_d = S_E0;
			S_E0:    state_d = S_E1;
			S_E1:    state_d = S_E2;
			S_E2:    state_d = S_E3;
			S_E3:    state_d = S_E4;
			S_E4:    state_d = S_OUT;
			S_OUT:   if (rsp_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// track target and wheel speed for the effort steps
	always_comb begin
		d_sel = dl_q;
		w_sel = wbl_q;
		case (state_q)
			S_E1:    w_sel = wfl_q;
			S_E2: begin
				d_sel = dr_q;
				w_sel = wbr_q;
			end
			S_E3: begin
				d_sel = dr_q;
				w_sel = wfr_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		request.ready = 1'b0;
		div_start     = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			S_IDLE: request.ready = 1'b1;
			S_VL: begin
				mul_a = {{(AW-17){sum_left[16]}}, sum_left};
				mul_b = wheel_radius_q;
			end
			S_VR: begin
				mul_a = {{(AW-18){neg_right[17]}}, neg_right};
				mul_b = wheel_radius_q;
			end
			S_DIV: div_start = 1'b1;
			S_ERR: begin
				mul_a = {{(AW-20){ev_q[19]}}, ev_q};
				mul_b = kp_linear_q;
			end
			S_KDV: begin
				mul_a = {{(AW-33){ev_d[32]}}, ev_d};
				mul_b = kd_linear_q;
			end
			S_KPW: begin
				mul_a = {{(AW-32){ew_q[31]}}, ew_q};
				mul_b = kp_angular_q;
			end
			S_KDW: begin
				mul_a = {{(AW-33){ew_d[32]}}, ew_d};
				mul_b = kd_angular_q;
			end
			S_H: begin
				mul_a = {{(AW-42){uw_q[41]}}, uw_q};
				mul_b = track_eff;
			end
			S_E0, S_E1, S_E2, S_E3: begin
				mul_a = {{(AW-45){dw[44]}}, dw};
				mul_b = wheel_gain_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			last_lin_q  <= '0;
			last_ang_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (result.ready)
				rsp_valid_q <= 1'b0;
			if (state_q == S_KDV)
				last_lin_q <= {{12{ev_q[19]}}, ev_q};
			if (state_q == S_KDW)
				last_ang_q <= ew_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= product;
		case (state_q)
			S_IDLE: begin
				wbl_q  <= request.data.speed_back_left;
				wfl_q  <= request.data.speed_front_left;
				wbr_q  <= request.data.speed_back_right;
				wfr_q  <= request.data.speed_front_right;
				vref_q <= vref_in;
				wref_q <= wref_in;
			end
			S_VR:  vl_q <= prod_q[33:15];
			S_LIN: vr_q <= prod_q[33:15];
			S_DIV: begin
				lin_q      <= lin_sum[19:1];
				ev_q       <= ev;
				diff_neg_q <= diff[19];
			end
			S_DIVW:
				if (div_stat.done)
					ang_q <= diff_neg_q ? (34'd0 - {2'b00, div_quo}) : {2'b00, div_quo};
			S_ERR: ew_q  <= ew_sat;
			S_KDV: acc_q <= prod_q;
			S_KPW: uv_q  <= pd_sum[49:8];
			S_KDW: acc_q <= prod_q;
			S_UW:  uw_q  <= pd_sum[49:8];
			S_D: begin
				dl_q <= uv_x - h_x;
				dr_q <= 44'd0 - (uv_x + h_x);
			end
			S_E1: eff_bl_q <= eff_cur;
			S_E2: eff_fl_q <= eff_cur;
			S_E3: eff_br_q <= eff_cur;
			S_E4: eff_fr_q <= eff_cur;
			S_OUT:
				if (rsp_free) begin
					rsp_q.effort_back_left   <= eff_bl_q;
					rsp_q.effort_front_left  <= eff_fl_q;
					rsp_q.effort_back_right  <= eff_br_q;
					rsp_q.effort_front_right <= eff_fr_q;
					rsp_q.body_linear_speed  <= ($signed(lin_q) > LIN_MAX) ? 16'h7FFF :
					                            ($signed(lin_q) < LIN_MIN) ? 16'h8000 :
					                            lin_q[15:0];
					rsp_q.body_angular_speed <= ($signed(ang_q) > ANG_MAX) ? 16'h7FFF :
					                            ($signed(ang_q) < ANG_MIN) ? 16'h8000 :
					                            ang_q[15:0];
				end
			default: ;
		endcase
	end

	assign result.valid = rsp_valid_q;
	assign result.data  = rsp_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIVW)
		else $error("divider finished outside its wait step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> state_q == S_VL)
		else $error("accepted beat did not start the sequence");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the output step");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && rsp_free |=> result.valid && state_q == S_IDLE)
		else $error("finished result not loaded");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_stat.busy)
		else $error("divider busy while idle");

endmodule
`default_nettype wire

[tb/effort_checker.sv]
module effort_checker
	import ssvc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W16-1:0]       cfg_wdata,
	input  logic                 cmd_valid,
	input  logic                 cmd_ready,
	input  ssvc_in_t             cmd_data,
	input  logic                 eff_valid,
	input  logic                 eff_ready,
	input  ssvc_out_t            eff_data,
	output int                   fail_count,
	output int                   beats_checked,
	output int                   backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     OUT_W   = $bits(ssvc_out_t);
	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -I32_MAX - 1;

	string field_name [6] = '{"effort_back_left", "effort_front_left", "effort_back_right",
		"effort_front_right", "body_linear_speed", "body_angular_speed"};

	longint radius  = longint'(RST_WHEEL_RADIUS);
	longint track_w = longint'(RST_TRACK_WIDTH);
	longint kp_lin  = longint'(RST_KP_LINEAR);
	longint kd_lin  = longint'(RST_KD_LINEAR);
	longint kp_ang  = longint'(RST_KP_ANGULAR);
	longint kd_ang  = longint'(RST_KD_ANGULAR);
	longint gain    = longint'(RST_WHEEL_GAIN);
	longint limit   = longint'(RST_EFFORT_LIMIT);
	int     prev_lin_err = 0;
	int     prev_ang_err = 0;

	ssvc_out_t pending_commands [$];
	ssvc_out_t want;
	int        bad_fields = 0;
	int        seen = 0;
	bit        wrong;

	function automatic longint clip(longint x, longint lo, longint hi);
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	// one control tick; updates the PD error history
	function automatic ssvc_out_t control_tick(ssvc_in_t t);
		longint    spd [4];
		longint    dem [4];
		longint    vref, wref, vl, vr, lin, diff, ang, ev, ew, uv, uw, h, tw, eff;
		ssvc_out_t o;
		spd[0] = longint'(t.speed_back_left);
		spd[1] = longint'(t.speed_front_left);
		spd[2] = longint'(t.speed_back_right);
		spd[3] = longint'(t.speed_front_right);
		vref = clip(longint'(t.linear_target), longint'(VREF_MIN), longint'(VREF_MAX));
		wref = clip(longint'(t.angular_target), longint'(WREF_MIN), longint'(WREF_MAX));
		tw = (track_w == 0) ? 1 : track_w;

		vl = ((spd[0] + spd[1]) * radius) >>> 15;
		vr = ((-(spd[2] + spd[3])) * radius) >>> 15;
		lin = (vl + vr) >>> 1;
		diff = vr - vl;
		ang = (diff * 16384) / tw;

		ev = clip(vref - lin, I32_MIN, I32_MAX);
		ew = clip(wref - ang, I32_MIN, I32_MAX);
		uv = (kp_lin * ev + kd_lin * (ev - longint'(prev_lin_err))) >>> 8;
		uw = (kp_ang * ew + kd_ang * (ew - longint'(prev_ang_err))) >>> 8;
		prev_lin_err = int'(ev);
		prev_ang_err = int'(ew);

		h = (tw * uw) >>> 15;
		dem[0] = uv - h;
		dem[1] = dem[0];
		dem[2] = -(uv + h);
		dem[3] = dem[2];
		for (int i = 0; i < 4; i++) begin
			eff = clip((gain * (dem[i] - spd[i])) >>> 8, -limit, limit);
			o[OUT_W-1-16*i -: 16] = eff[15:0];
		end
		o.body_linear_speed  = 16'(clip(lin, -32768, 32767));
		o.body_angular_speed = 16'(clip(ang, -32768, 32767));
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius = longint'(RST_WHEEL_RADIUS);
			track_w = longint'(RST_TRACK_WIDTH);
			kp_lin = longint'(RST_KP_LINEAR);
			kd_lin = longint'(RST_KD_LINEAR);
			kp_ang = longint'(RST_KP_ANGULAR);
			kd_ang = longint'(RST_KD_ANGULAR);
			gain = longint'(RST_WHEEL_GAIN);
			limit = longint'(RST_EFFORT_LIMIT);
			prev_lin_err = 0;
			prev_ang_err = 0;
			pending_commands.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WHEEL_RADIUS: radius = longint'(cfg_wdata);
					REG_TRACK_WIDTH:  track_w = longint'(cfg_wdata);
					REG_KP_LINEAR:    kp_lin = longint'(cfg_wdata);
					REG_KD_LINEAR:    kd_lin = longint'(cfg_wdata);
					REG_KP_ANGULAR:   kp_ang = longint'(cfg_wdata);
					REG_KD_ANGULAR:   kd_ang = longint'(cfg_wdata);
					REG_WHEEL_GAIN:   gain = longint'(cfg_wdata);
					REG_EFFORT_LIMIT: limit = longint'(cfg_wdata[LIM_W-1:0]);
					default: ;
				endcase
			end

			if (eff_valid && eff_ready) begin
				if (pending_commands.size() == 0) begin
					bad_fields++;
					if (bad_fields <= 10)
						$display("unexpected result beat: %p", eff_data);
				end else begin
					want = pending_commands.pop_front();
					for (int f = 0; f < 6; f++) begin
						wrong = eff_data[OUT_W-1-16*f -: 16] !== want[OUT_W-1-16*f -: 16];
						if (wrong) begin
							bad_fields++;
							if (bad_fields <= 10)
								$display("beat %0d %s: expected %0d, got %0d", seen,
									field_name[f], $signed(want[OUT_W-1-16*f -: 16]),
									$signed(eff_data[OUT_W-1-16*f -: 16]));
						end
					end
				end
				seen++;
			end

			if (cmd_valid && cmd_ready)
				pending_commands.push_back(control_tick(cmd_data));

			fail_count <= bad_fields;
			beats_checked <= seen;
			backlog <= pending_commands.size();
		end
	end

endmodule

[tb/tb.sv]
module tb;
	import ssvc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_BEATS = 69;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [W16-1:0] cfg_wdata;

	int  fail_count;
	int  beats_checked;
	int  backlog;
	int  beats_sent = 0;
	int  cycles = 0;
	int  stall = 0;
	bit  calm = 1'b0;

	ssvc_stream_if #(.payload_t(ssvc_in_t))  req_ch ();
	ssvc_stream_if #(.payload_t(ssvc_out_t)) res_ch ();

	skid_steer_velocity_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.request   (req_ch),
		.result    (res_ch)
	);

	effort_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.cmd_valid     (req_ch.valid),
		.cmd_ready     (req_ch.ready),
		.cmd_data      (req_ch.data),
		.eff_valid     (res_ch.valid),
		.eff_ready     (res_ch.ready),
		.eff_data      (res_ch.data),
		.fail_count    (fail_count),
		.beats_checked (beats_checked),
		.backlog       (backlog)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: short random stalls plus the odd long one
	always @(posedge clk) begin
		if (stall > 0) begin
			stall <= stall - 1;
			res_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(1999) == 0) begin
			stall <= $urandom_range(120, 20);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= calm || ($urandom_range(99) >= 23);
		end
	end

	function automatic ssvc_in_t mk(input logic signed [W16-1:0] bl, fl, br, fr, lt, at);
		ssvc_in_t c;
		c.speed_back_left   = bl;
		c.speed_front_left  = fl;
		c.speed_back_right  = br;
		c.speed_front_right = fr;
		c.linear_target     = lt;
		c.angular_target    = at;
		return c;
	endfunction

	function automatic logic [W16-1:0] corner();
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [W16-1:0] rand_reg();
		case ($urandom_range(4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic ssvc_in_t rand_cmd();
		int base, turn;
		ssvc_in_t c;
		case ($urandom_range(9))
			0, 1: c = {$urandom, $urandom, $urandom};
			2: c = mk(corner(), corner(), corner(), corner(), corner(), corner());
			default: begin
				// plausible drive: right wheels mirror the left
				base = int'($urandom_range(4000)) - 2000;
				turn = int'($urandom_range(1000)) - 500;
				c.speed_back_left   = 16'(base - turn + int'($urandom_range(64)) - 32);
				c.speed_front_left  = 16'(base - turn + int'($urandom_range(64)) - 32);
				c.speed_back_right  = 16'(-(base + turn) + int'($urandom_range(64)) - 32);
				c.speed_front_right = 16'(-(base + turn) + int'($urandom_range(64)) - 32);
				c.linear_target     = 16'(int'($urandom_range(7000)) - 3500);
				c.angular_target    = 16'(int'($urandom_range(800)) - 400);
			end
		endcase
		return c;
	endfunction

	task automatic send(input ssvc_in_t beat);
		int gap;
		gap = 0;
		if (!calm) begin
			if ($urandom_range(11) == 0)
				gap = $urandom_range(80, 1);
			else
				while ($urandom_range(99) < 23)
					gap++;
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= beat;
		do
			@(posedge clk);
		while (!req_ch.ready);
		beats_sent++;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (beats_checked != beats_sent);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [W16-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic tune(input logic [W16-1:0] r, t, kpl, kdl, kpa, kda, g, lim);
		put_reg(REG_WHEEL_RADIUS, r);
		put_reg(REG_TRACK_WIDTH, t);
		put_reg(REG_KP_LINEAR, kpl);
		put_reg(REG_KD_LINEAR, kdl);
		put_reg(REG_KP_ANGULAR, kpa);
		put_reg(REG_KD_ANGULAR, kda);
		put_reg(REG_WHEEL_GAIN, g);
		put_reg(REG_EFFORT_LIMIT, lim);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		res_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: field extremes and reference clamps
		send(mk(0, 0, 0, 0, 0, 0));
		send(mk(32767, 32767, 32767, 32767, 32767, 32767));
		send(mk(-32768, -32768, -32768, -32768, -32768, -32768));
		send(mk(256, 256, -256, -256, 2560, 256));
		send(mk(0, 0, 0, 0, 2561, 257));
		send(mk(0, 0, 0, 0, -2561, -257));
		send(mk(0, 0, 0, 0, -2560, -256));
		send(mk(32767, 32767, -32768, -32768, 0, 0));
		send(mk(-32768, -32768, 32767, 32767, 0, 0));
		send(mk(1, -1, -1, 1, 1, -1));
		send(mk(21845, -21846, 21845, -21846, 21845, -21846));
		send(mk(-21846, 21845, -21846, 21845, -21846, 21845));
		req_ch.valid <= 1'b0;
		drain();

		// zero track width, full gains: turn-rate error saturates both ways;
		// bit 15 of the limit write must be dropped
		tune(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(mk(32767, 32767, 32767, 32767, 0, 0));
		send(mk(-32768, -32768, -32768, -32768, 0, 0));
		send(mk(32767, 32767, 32767, 32767, -32768, 32767));
		send(mk(0, 0, 0, 0, 0, 0));
		send(mk(-32768, -32768, 32767, 32767, 32767, -32768));
		req_ch.valid <= 1'b0;
		drain();

		// zero effort limit
		tune(RST_WHEEL_RADIUS, 16'd1, RST_KP_LINEAR, 16'd300, RST_KP_ANGULAR, 16'd300,
			RST_WHEEL_GAIN, 16'h0000);
		send(mk(1000, 1000, -900, -900, 2000, -100));
		send(mk(32767, 32767, 32767, 32767, 32767, 32767));
		send(mk(-32768, -32768, -32768, -32768, -32768, -32768));
		req_ch.valid <= 1'b0;
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: tune(RST_WHEEL_RADIUS, RST_TRACK_WIDTH, RST_KP_LINEAR, 16'd512,
					RST_KP_ANGULAR, 16'd256, RST_WHEEL_GAIN, {1'b0, RST_EFFORT_LIMIT});
				2: tune(16'($urandom_range(4000, 1000)), 16'($urandom_range(16000, 4000)),
					16'($urandom_range(4000)), 16'($urandom_range(1000)),
					16'($urandom_range(8000)), 16'($urandom_range(1000)),
					16'($urandom_range(4000)), 16'($urandom_range(32767)));
				3: tune(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
					16'h0000, 16'h0000);
				4: tune(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'hFFFF, 16'h7FFF);
				default: tune(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
					rand_reg(), rand_reg(), rand_reg());
			endcase
			calm = (ph == 2);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (ph == 5 && n == PHASE_BEATS / 2) begin
					req_ch.valid <= 1'b0;
					drain();
				end
				send(rand_cmd());
			end
			req_ch.valid <= 1'b0;
			drain();
		end
		calm = 1'b0;

		repeat (60) @(posedge clk);
		if (fail_count == 0 && backlog == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
